@@ hdl/wss_pkg.sv @@
// ----------------------------------------------------------------------------
// wss_pkg: shared types and constants for the windowed stream statistics block
// Holds the stream table entry layout, the result record, the arithmetic unit
// request and response, and the command, verdict and register codes.
// ----------------------------------------------------------------------------
package wss_pkg;

  // Command codes of an input request.
  localparam logic CMD_SAMPLE = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Result kinds.
  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_STATS   = 1'b1;

  // Packet verdicts.
  localparam logic [1:0] VERDICT_GOOD    = 2'd0;
  localparam logic [1:0] VERDICT_FUTURE  = 2'd1;
  localparam logic [1:0] VERDICT_EXPIRED = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_WINDOW_SECONDS = 2'd0;
  localparam logic [1:0] REG_MAX_LATENCY    = 2'd1;
  localparam logic [1:0] REG_MAX_FUTURE     = 2'd2;

  localparam logic [19:0] US_PER_S = 20'd1000000;
  localparam logic [31:0] MAX32    = 32'hFFFF_FFFF;
  localparam logic [39:0] MAX40    = 40'hFF_FFFF_FFFF;
  localparam logic [55:0] MAX56    = 56'hFF_FFFF_FFFF_FFFF;

  // Shared arithmetic unit operations.
  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV,
    ALU_SQRT
  } alu_op_t;

  typedef struct packed {
    logic          start;
    alu_op_t       op;
    logic [127:0]  a;
    logic [63:0]   b;
    logic [5:0]    extra;
  } alu_req_t;

  typedef struct packed {
    logic          done;
    logic [127:0]  result;
  } alu_rsp_t;

  // One row of the stream table.
  typedef struct packed {
    logic               active;
    logic [31:0]        total;
    logic [31:0]        good;
    logic [31:0]        future;
    logic [31:0]        expired;
    logic [62:0]        wstart;
    logic signed [55:0] wsum;
    logic [63:0]        wsq;
    logic [31:0]        wsamp;
    logic [31:0]        wpkt;
    logic [55:0]        wlat;
  } entry_t;

  // One result record.
  typedef struct packed {
    logic               kind;
    logic [3:0]         stream;
    logic [1:0]         verdict;
    logic [31:0]        total;
    logic [31:0]        good;
    logic [31:0]        future;
    logic [31:0]        expired;
    logic [39:0]        lat;
    logic [31:0]        mean;
    logic [31:0]        sd;
    logic               last;
  } res_t;

  // Counter increment that sticks at the top.
  function automatic logic [31:0] sat_inc32(input logic [31:0] c);
    return (c == MAX32) ? c : c + 32'd1;
  endfunction

endpackage

@@ hdl/wss_ram.sv @@
// ----------------------------------------------------------------------------
// wss_ram: generic single write, single read RAM
// One write port and one read port with registered read data that holds
// while no read is issued.
// ----------------------------------------------------------------------------
module wss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                             clk,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hdl/wss_alu.sv @@
// ----------------------------------------------------------------------------
// wss_alu: shared iterative arithmetic unit
// Shift-add multiply, restoring divide with extra fraction bits and 64-bit
// saturation, and integer square root. One bit or one root digit per cycle.
// ----------------------------------------------------------------------------
module wss_alu (
  input  logic              clk,
  input  logic              rst,
  input  wss_pkg::alu_req_t req,
  output wss_pkg::alu_rsp_t rsp
);
  import wss_pkg::*;

  logic         busy;
  logic         done;
  alu_op_t      op;
  logic [7:0]   cnt;
  logic [127:0] acc;
  logic [63:0]  opa;
  logic [63:0]  opb;
  logic [63:0]  rem;
  logic [63:0]  quo;
  logic         sat;
  logic [63:0]  root;
  logic [63:0]  bitv;

  logic [127:0] mul_next;
  logic [64:0]  div_r2;
  logic         div_ge;
  logic [63:0]  rem_next;
  logic [63:0]  trial;
  logic         sq_ge;

  // One step of each operation.
  always_comb begin
    mul_next = {acc[126:0], 1'b0} + (opb[63] ? {64'b0, opa} : 128'b0);
    div_r2   = {rem, acc[127]};
    div_ge   = div_r2 >= {1'b0, opb};
    rem_next = div_ge ? 64'(div_r2 - {1'b0, opb}) : div_r2[63:0];
    trial    = root + bitv;
    sq_ge    = opa >= trial;
  end

  // Sequencer and datapath registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      op   <= ALU_MUL;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (!busy && req.start) begin
        busy <= 1'b1;
        op   <= req.op;
        rem  <= '0;
        quo  <= '0;
        sat  <= 1'b0;
        root <= '0;
        bitv <= 64'h4000_0000_0000_0000;
        opb  <= req.b;
        unique case (req.op)
          ALU_MUL: begin
            acc <= '0;
            opa <= req.a[63:0];
            cnt <= 8'd63;
          end
          ALU_DIV: begin
            acc <= req.a;
            opa <= '0;
            cnt <= 8'd127 + {2'b0, req.extra};
          end
          ALU_SQRT: begin
            acc <= '0;
            opa <= req.a[63:0];
            cnt <= 8'd31;
          end
          default: begin
            acc <= '0;
            opa <= '0;
            cnt <= '0;
          end
        endcase
      end else if (busy) begin
        unique case (op)
          ALU_MUL: begin
            acc <= mul_next;
            opb <= {opb[62:0], 1'b0};
          end
          ALU_DIV: begin
            acc <= {acc[126:0], 1'b0};
            rem <= rem_next;
            sat <= sat | quo[63];
            quo <= {quo[62:0], div_ge};
          end
          ALU_SQRT: begin
            if (sq_ge) begin
              opa  <= opa - trial;
              root <= (root >> 1) + bitv;
            end else begin
              root <= root >> 1;
            end
            bitv <= bitv >> 2;
          end
          default: begin
            acc <= acc;
          end
        endcase
        cnt <= cnt - 8'd1;
        if (cnt == 8'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Result of the last finished operation.
  always_comb begin
    rsp.done = done;
    unique case (op)
      ALU_MUL:  rsp.result = acc;
      ALU_DIV:  rsp.result = {64'b0, sat ? {64{1'b1}} : quo};
      ALU_SQRT: rsp.result = {64'b0, root};
      default:  rsp.result = '0;
    endcase
  end

endmodule

@@ hdl/windowed_stream_stats.sv @@
// ----------------------------------------------------------------------------
// windowed_stream_stats: per-stream packet timeliness and window statistics
// Samples build a packet; the closing sample judges it and commits good
// packets to the stream's window. A tick closes every due window and reports
// mean latency, mean and standard deviation.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake            Payload
//  cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//  in       in         in_valid/in_ready    cmd, stream, sample_value, last_sample,
//                                           start_us, end_us, now_us
//  out      out        out_valid/out_ready  kind, out_stream, verdict, counters,
//                                           mean_latency_us, mean_value, std_value, last
//
//  A sample request passes S_SQ and S_ACC; a closing sample also passes S_RD
//  and S_JUDGE, which waits for the output register. A tick walks every
//  stream row; a due window adds work on the shared multiply, divide and root unit.
//  After reset a clearing pass over all NUM_STREAMS rows runs before in_ready.
//  A stalled output holds the sequencer only where a new result must be put.
// ----------------------------------------------------------------------------
module windowed_stream_stats #(
  parameter int NUM_STREAMS = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [39:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               cmd,
  input  logic [3:0]         stream,
  input  logic signed [23:0] sample_value,
  input  logic               last_sample,
  input  logic [62:0]        start_us,
  input  logic [62:0]        end_us,
  input  logic [62:0]        now_us,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               kind,
  output logic [3:0]         out_stream,
  output logic [1:0]         verdict,
  output logic [31:0]        total_count,
  output logic [31:0]        good_count,
  output logic [31:0]        future_count,
  output logic [31:0]        expired_count,
  output logic [39:0]        mean_latency_us,
  output logic signed [31:0] mean_value,
  output logic [31:0]        std_value,
  output logic               last
);
  import wss_pkg::*;

  localparam int AW = $clog2(NUM_STREAMS > 1 ? NUM_STREAMS : 2);
  localparam int IW = $clog2(NUM_STREAMS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_STREAMS - 1);

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_SQ, S_ACC, S_RD, S_JUDGE,
    T_WIN, T_RD, T_CHK, T_LAT, T_LAT_D, T_MEAN, T_MEAN_D,
    T_SQ1_D, T_SQ2_D, T_M_D, T_DIFF, T_DIV, T_DIV_D, T_SQRT_D,
    T_PUSH, T_NEXT, T_END, A_WAIT
  } state_t;

  state_t state;
  state_t ret;

  // Configuration registers.
  logic [11:0] window_seconds;
  logic [39:0] max_latency_us;
  logic [39:0] max_future_us;

  // Held request.
  logic [3:0]         stream_r;
  logic signed [23:0] val_r;
  logic               last_r;
  logic [62:0]        start_r;
  logic [62:0]        end_r;
  logic [62:0]        now_r;

  // Packet accumulator.
  logic signed [47:0] pkt_sum;
  logic [63:0]        pkt_sq;
  logic [31:0]        pkt_n;
  logic [47:0]        sq_prod;

  // Judging and window work registers.
  logic [63:0]  fut_lim;
  logic [63:0]  exp_lim;
  logic [62:0]  lat_pkt;
  logic [31:0]  win_us;
  logic [IW-1:0] idx;
  entry_t       ent;
  logic [39:0]  lat_r;
  logic [31:0]  mean_r;
  logic [31:0]  sd_r;
  logic [127:0] sq_r;
  logic [127:0] t_r;
  logic [127:0] diff_r;
  logic [63:0]  m_r;

  // Pending tick result and output register.
  logic hold_valid;
  res_t hold;
  res_t out_r;

  // Stream table and arithmetic unit.
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic          ram_re;
  logic [AW-1:0] ram_raddr;
  entry_t        ram_rd;
  alu_req_t      alu_req;
  alu_rsp_t      alu_rsp;

  wss_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(NUM_STREAMS)
  ) u_table (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(ram_waddr),
    .wr_data(ram_wdata),
    .rd_en  (ram_re),
    .rd_addr(ram_raddr),
    .rd_data(ram_rd)
  );

  wss_alu u_alu (
    .clk(clk),
    .rst(rst),
    .req(alu_req),
    .rsp(alu_rsp)
  );

  // Packet accumulation terms.
  logic signed [47:0] prod_w;
  logic signed [48:0] psum_w;
  logic [64:0]        psq_w;
  logic               stream_bad;

  assign prod_w     = val_r * val_r;
  assign psum_w     = {pkt_sum[47], pkt_sum} + {{25{val_r[23]}}, val_r};
  assign psq_w      = {1'b0, pkt_sq} + {17'b0, sq_prod};
  assign stream_bad = {7'b0, stream_r} >= 11'(NUM_STREAMS);

  // Verdict and updated table row for a closing sample.
  logic [1:0]  judge_v;
  entry_t      judge_ent;
  entry_t      wbase;
  logic signed [56:0] wsum_w;
  logic [64:0] wsq_w;
  logic [32:0] wsamp_w;
  logic [63:0] wlat_w;

  always_comb begin
    if ({1'b0, end_r} > fut_lim) begin
      judge_v = VERDICT_FUTURE;
    end else if (exp_lim < {1'b0, now_r}) begin
      judge_v = VERDICT_EXPIRED;
    end else begin
      judge_v = VERDICT_GOOD;
    end
    wbase = ram_rd;
    if (!ram_rd.active) begin
      wbase.active = 1'b1;
      wbase.wstart = now_r;
      wbase.wsum   = '0;
      wbase.wsq    = '0;
      wbase.wsamp  = '0;
      wbase.wpkt   = '0;
      wbase.wlat   = '0;
    end
    wsum_w  = {wbase.wsum[55], wbase.wsum} + {{9{pkt_sum[47]}}, pkt_sum};
    wsq_w   = {1'b0, wbase.wsq} + {1'b0, pkt_sq};
    wsamp_w = {1'b0, wbase.wsamp} + {1'b0, pkt_n};
    wlat_w  = {8'b0, wbase.wlat} + {1'b0, lat_pkt};
    judge_ent       = ram_rd;
    judge_ent.total = sat_inc32(ram_rd.total);
    unique case (judge_v)
      VERDICT_FUTURE:  judge_ent.future  = sat_inc32(ram_rd.future);
      VERDICT_EXPIRED: judge_ent.expired = sat_inc32(ram_rd.expired);
      default: begin
        judge_ent.good   = sat_inc32(ram_rd.good);
        judge_ent.active = 1'b1;
        judge_ent.wstart = wbase.wstart;
        if (wsum_w[56] != wsum_w[55]) begin
          judge_ent.wsum = wsum_w[56] ? {1'b1, 55'b0} : {1'b0, {55{1'b1}}};
        end else begin
          judge_ent.wsum = wsum_w[55:0];
        end
        judge_ent.wsq   = wsq_w[64] ? {64{1'b1}} : wsq_w[63:0];
        judge_ent.wsamp = wsamp_w[32] ? MAX32 : wsamp_w[31:0];
        judge_ent.wpkt  = sat_inc32(wbase.wpkt);
        judge_ent.wlat  = (wlat_w > {8'b0, MAX56}) ? MAX56 : wlat_w[55:0];
      end
    endcase
  end

  // Window terms for a tick.
  logic               due;
  logic [55:0]        s1_mag;
  logic [63:0]        q_w;
  logic [31:0]        mean_fmt;
  logic [39:0]        lat_fmt;
  res_t               tick_res;
  res_t               judge_res;

  always_comb begin
    due = ram_rd.active &&
          ({1'b0, now_r} >= ({1'b0, ram_rd.wstart} + {32'b0, win_us}));
    s1_mag = ent.wsum[55] ? 56'(-ent.wsum) : ent.wsum;
    q_w    = alu_rsp.result[63:0];
    if (ent.wsum[55]) begin
      mean_fmt = (q_w > 64'h8000_0000) ? 32'h8000_0000 : 32'(-q_w[31:0]);
    end else begin
      mean_fmt = (q_w > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q_w[31:0];
    end
    lat_fmt = (q_w > {24'b0, MAX40}) ? MAX40 : q_w[39:0];

    tick_res.kind    = KIND_STATS;
    tick_res.stream  = 4'(idx);
    tick_res.verdict = VERDICT_GOOD;
    tick_res.total   = ent.total;
    tick_res.good    = ent.good;
    tick_res.future  = ent.future;
    tick_res.expired = ent.expired;
    tick_res.lat     = lat_r;
    tick_res.mean    = mean_r;
    tick_res.sd      = sd_r;
    tick_res.last    = 1'b0;

    judge_res.kind    = KIND_VERDICT;
    judge_res.stream  = stream_r;
    judge_res.verdict = judge_v;
    judge_res.total   = judge_ent.total;
    judge_res.good    = judge_ent.good;
    judge_res.future  = judge_ent.future;
    judge_res.expired = judge_ent.expired;
    judge_res.lat     = '0;
    judge_res.mean    = '0;
    judge_res.sd      = '0;
    judge_res.last    = 1'b0;
  end

  logic slot_free;
  logic out_load;
  assign slot_free = !out_valid || out_ready;

  // The output register takes a new result in this cycle.
  assign out_load = slot_free && ((state == S_JUDGE) ||
                    (((state == T_PUSH) || (state == T_END)) && hold_valid));

  // Table port and arithmetic unit requests.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(idx);
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = AW'(idx);
    alu_req   = '0;
    unique case (state)
      S_CLR: begin
        ram_we = 1'b1;
      end
      S_RD: begin
        ram_re    = 1'b1;
        ram_raddr = AW'(stream_r);
      end
      S_JUDGE: begin
        ram_we    = slot_free;
        ram_waddr = AW'(stream_r);
        ram_wdata = judge_ent;
      end
      T_RD: begin
        ram_re = 1'b1;
      end
      T_LAT: begin
        alu_req.start = ent.wpkt != 32'd0;
        alu_req.op    = ALU_DIV;
        alu_req.a     = {72'b0, ent.wlat} + {97'b0, ent.wpkt[31:1]};
        alu_req.b     = {32'b0, ent.wpkt};
      end
      T_MEAN: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_DIV;
        alu_req.a     = ({72'b0, s1_mag} << FRAC_BITS) + {97'b0, ent.wsamp[31:1]};
        alu_req.b     = {32'b0, ent.wsamp};
      end
      T_MEAN_D: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_MUL;
        alu_req.a     = {72'b0, s1_mag};
        alu_req.b     = {8'b0, s1_mag};
      end
      T_SQ1_D: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_MUL;
        alu_req.a     = {64'b0, ent.wsq};
        alu_req.b     = {32'b0, ent.wsamp};
      end
      T_SQ2_D: begin
        alu_req.start = ent.wsamp > 32'd1;
        alu_req.op    = ALU_MUL;
        alu_req.a     = {96'b0, ent.wsamp};
        alu_req.b     = {32'b0, ent.wsamp - 32'd1};
      end
      T_DIV: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_DIV;
        alu_req.a     = diff_r;
        alu_req.b     = m_r;
        alu_req.extra = 6'(2 * FRAC_BITS);
      end
      T_DIV_D: begin
        alu_req.start = 1'b1;
        alu_req.op    = ALU_SQRT;
        alu_req.a     = {64'b0, q_w};
      end
      T_PUSH: begin
        ram_we = !hold_valid || slot_free;
        ram_wdata = ent;
        ram_wdata.wstart = now_r;
        ram_wdata.wsum   = '0;
        ram_wdata.wsq    = '0;
        ram_wdata.wsamp  = '0;
        ram_wdata.wpkt   = '0;
        ram_wdata.wlat   = '0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);

  // Sequencer, working registers and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_CLR;
      ret            <= S_IDLE;
      idx            <= '0;
      window_seconds <= 12'd60;
      max_latency_us <= 40'd600000000;
      max_future_us  <= '0;
      pkt_sum        <= '0;
      pkt_sq         <= '0;
      pkt_n          <= '0;
      hold_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_WINDOW_SECONDS: window_seconds <= cfg_data[11:0];
          REG_MAX_LATENCY:    max_latency_us <= cfg_data;
          REG_MAX_FUTURE:     max_future_us  <= cfg_data;
          default:            window_seconds <= window_seconds;
        endcase
      end
      unique case (state)
        S_CLR: begin
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            stream_r <= stream;
            val_r    <= sample_value;
            last_r   <= last_sample;
            start_r  <= start_us;
            end_r    <= end_us;
            now_r    <= now_us;
            state    <= (cmd == CMD_TICK) ? T_WIN : S_SQ;
          end
        end
        S_SQ: begin
          sq_prod <= prod_w;
          state   <= S_ACC;
        end
        S_ACC: begin
          if (last_r && stream_bad) begin
            // A packet closed on a stream outside the table is dropped.
            pkt_sum <= '0;
            pkt_sq  <= '0;
            pkt_n   <= '0;
            state   <= S_IDLE;
          end else begin
            if (psum_w[48] != psum_w[47]) begin
              pkt_sum <= psum_w[48] ? {1'b1, 47'b0} : {1'b0, {47{1'b1}}};
            end else begin
              pkt_sum <= psum_w[47:0];
            end
            pkt_sq <= psq_w[64] ? {64{1'b1}} : psq_w[63:0];
            pkt_n  <= sat_inc32(pkt_n);
            state  <= last_r ? S_RD : S_IDLE;
          end
        end
        S_RD: begin
          fut_lim <= {1'b0, now_r} + {24'b0, max_future_us};
          exp_lim <= {1'b0, start_r} + {24'b0, max_latency_us};
          lat_pkt <= (now_r > end_r) ? now_r - end_r : '0;
          state   <= S_JUDGE;
        end
        S_JUDGE: begin
          if (slot_free) begin
            out_r     <= judge_res;
            pkt_sum   <= '0;
            pkt_sq    <= '0;
            pkt_n     <= '0;
            state     <= S_IDLE;
          end
        end
        T_WIN: begin
          win_us <= (window_seconds == 12'd0 ? 32'd1 : {20'b0, window_seconds}) *
                    {12'b0, US_PER_S};
          idx    <= '0;
          state  <= T_RD;
        end
        T_RD: begin
          state <= T_CHK;
        end
        T_CHK: begin
          ent <= ram_rd;
          if (!due) begin
            state <= T_NEXT;
          end else if (ram_rd.wsamp == 32'd0) begin
            lat_r  <= win_us[31:0] == 32'd0 ? 40'd0 : {8'b0, win_us};
            mean_r <= '0;
            sd_r   <= '0;
            state  <= T_PUSH;
          end else begin
            state <= T_LAT;
          end
        end
        T_LAT: begin
          if (ent.wpkt == 32'd0) begin
            lat_r <= {8'b0, win_us};
            state <= T_MEAN;
          end else begin
            ret   <= T_LAT_D;
            state <= A_WAIT;
          end
        end
        T_LAT_D: begin
          lat_r <= lat_fmt;
          state <= T_MEAN;
        end
        T_MEAN: begin
          ret   <= T_MEAN_D;
          state <= A_WAIT;
        end
        T_MEAN_D: begin
          mean_r <= mean_fmt;
          ret    <= T_SQ1_D;
          state  <= A_WAIT;
        end
        T_SQ1_D: begin
          sq_r  <= alu_rsp.result;
          ret   <= T_SQ2_D;
          state <= A_WAIT;
        end
        T_SQ2_D: begin
          t_r <= alu_rsp.result;
          if (ent.wsamp > 32'd1) begin
            ret   <= T_M_D;
            state <= A_WAIT;
          end else begin
            m_r   <= 64'd1;
            state <= T_DIFF;
          end
        end
        T_M_D: begin
          m_r   <= alu_rsp.result[63:0];
          state <= T_DIFF;
        end
        T_DIFF: begin
          if (t_r < sq_r) begin
            sd_r  <= '0;
            state <= T_PUSH;
          end else begin
            diff_r <= t_r - sq_r;
            state  <= T_DIV;
          end
        end
        T_DIV: begin
          ret   <= T_DIV_D;
          state <= A_WAIT;
        end
        T_DIV_D: begin
          ret   <= T_SQRT_D;
          state <= A_WAIT;
        end
        T_SQRT_D: begin
          sd_r  <= alu_rsp.result[31:0];
          state <= T_PUSH;
        end
        T_PUSH: begin
          if (!hold_valid || slot_free) begin
            if (hold_valid) begin
              out_r <= hold;
            end
            hold       <= tick_res;
            hold_valid <= 1'b1;
            state      <= T_NEXT;
          end
        end
        T_NEXT: begin
          if (idx == LAST_IDX) begin
            state <= T_END;
          end else begin
            idx   <= idx + 1'b1;
            state <= T_RD;
          end
        end
        T_END: begin
          if (!hold_valid) begin
            state <= S_IDLE;
          end else if (slot_free) begin
            // The final result of a tick carries the end mark in its low bit.
            out_r      <= {hold[$bits(res_t)-1:1], 1'b1};
            hold_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        A_WAIT: begin
          if (alu_rsp.done) begin
            state <= ret;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output ports.
  assign kind            = out_r.kind;
  assign out_stream      = out_r.stream;
  assign verdict         = out_r.verdict;
  assign total_count     = out_r.total;
  assign good_count      = out_r.good;
  assign future_count    = out_r.future;
  assign expired_count   = out_r.expired;
  assign mean_latency_us = out_r.lat;
  assign mean_value      = out_r.mean;
  assign std_value       = out_r.sd;
  assign last            = out_r.last;

  // A new request is never taken while one is still in work.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

  // The arithmetic unit finishes only while the sequencer waits on it.
  a_alu_done_wait: assert property (@(posedge clk) disable iff (rst)
    alu_rsp.done |-> (state == A_WAIT))
    else $error("arithmetic result arrived outside its wait state");

  // A pending tick result never survives into idle.
  a_hold_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !hold_valid)
    else $error("tick result left pending");

  // Verdict results never carry the tick end mark.
  a_verdict_not_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_VERDICT)) |-> !last)
    else $error("verdict result marked last");

endmodule

@@ dv/tb_windowed_stream_stats.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_windowed_stream_stats: self-checking testbench for windowed_stream_stats
// A queue-fed driver offers sample and tick requests while a clocked monitor
// compares every result with a cycle-free model of the stream table. The run
// walks several register settings, with random idling on both channels and
// one long receiver stall.
// ----------------------------------------------------------------------------
module tb_windowed_stream_stats;
  import wss_pkg::*;

  localparam int          FRAC        = 8;
  localparam int          NSTR        = 16;
  localparam int          HOLD_CYCLES = 400;
  localparam logic [62:0] TMAX        = {63{1'b1}};
  localparam logic [62:0] T0          = 63'd1 << 50;
  localparam logic [1:0]  REG_SPARE   = 2'd3;

  typedef struct {
    logic               cmd;
    logic [3:0]         strm;
    logic signed [23:0] val;
    logic               lst;
    logic [62:0]        st;
    logic [62:0]        en;
    logic [62:0]        nw;
  } req_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [39:0]        cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               cmd = 1'b0;
  logic [3:0]         stream = '0;
  logic signed [23:0] sample_value = '0;
  logic               last_sample = 1'b0;
  logic [62:0]        start_us = '0;
  logic [62:0]        end_us = '0;
  logic [62:0]        now_us = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               kind;
  logic [3:0]         out_stream;
  logic [1:0]         verdict;
  logic [31:0]        total_count;
  logic [31:0]        good_count;
  logic [31:0]        future_count;
  logic [31:0]        expired_count;
  logic [39:0]        mean_latency_us;
  logic signed [31:0] mean_value;
  logic [31:0]        std_value;
  logic               last;

  windowed_stream_stats u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .cmd(cmd), .stream(stream),
    .sample_value(sample_value), .last_sample(last_sample), .start_us(start_us),
    .end_us(end_us), .now_us(now_us),
    .out_valid(out_valid), .out_ready(out_ready), .kind(kind), .out_stream(out_stream),
    .verdict(verdict), .total_count(total_count), .good_count(good_count),
    .future_count(future_count), .expired_count(expired_count),
    .mean_latency_us(mean_latency_us), .mean_value(mean_value), .std_value(std_value),
    .last(last)
  );

  // Clock.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model copy of the registers and the stream table.
  logic [11:0]        m_win_s;
  logic [39:0]        m_maxlat;
  logic [39:0]        m_maxfut;
  longint             p_sum;
  logic [63:0]        p_sq;
  logic [31:0]        p_n;
  longint             w_sum [NSTR];
  logic [63:0]        w_sq [NSTR];
  logic [31:0]        w_n [NSTR];
  logic [31:0]        w_pk [NSTR];
  logic [63:0]        w_lat [NSTR];
  logic [63:0]        w_start [NSTR];
  bit                 w_act [NSTR];
  logic [31:0]        c_tot [NSTR];
  logic [31:0]        c_good [NSTR];
  logic [31:0]        c_fut [NSTR];
  logic [31:0]        c_exp [NSTR];

  req_t               sample_feed[$];
  res_t               pending_results[$];
  logic [63:0]        t_sim = {1'b0, T0};
  int                 cyc = 0;
  int                 n_acc = 0;
  int                 n_res = 0;
  int                 n_windows = 0;
  int                 n_bad = 0;
  bit                 in_fire = 1'b0;
  int                 hold_left = 0;
  bit                 hold_done = 1'b0;
  res_t               got;
  res_t               want;

  function automatic longint clamp_s(longint s, longint lim);
    if (s > lim - 1) return lim - 1;
    if (s < -lim) return -lim;
    return s;
  endfunction

  function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b, logic [63:0] mx);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return (s > {1'b0, mx}) ? mx : s[63:0];
  endfunction

  function automatic logic [31:0] bump(logic [31:0] c);
    return (c == MAX32) ? c : c + 32'd1;
  endfunction

  function automatic logic [63:0] root_floor(logic [63:0] x);
    logic [63:0] r, t;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  // Mean with FRAC fraction bits, rounded half away from zero and saturated.
  function automatic logic [31:0] mean_fix(longint s1, logic [63:0] n);
    logic        neg;
    logic [63:0] a, q, r, mag;
    neg = s1 < 0;
    a = neg ? -s1 : s1;
    q = a / n;
    r = a % n;
    if (q > 64'hFFFF_FFFF) mag = '1;
    else mag = (q << FRAC) + (((r << FRAC) + n / 2) / n);
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      mag = -mag;
      return mag[31:0];
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  // Sample standard deviation with the correction applied to the variance.
  function automatic logic [31:0] std_fix(longint s1, logic [63:0] s2, logic [63:0] n);
    logic [63:0]  a, m, rt;
    logic [127:0] sq, t, d;
    logic [143:0] q;
    a = (s1 < 0) ? -s1 : s1;
    sq = a * a;
    t = n * s2;
    if (t < sq) return '0;
    d = t - sq;
    m = (n > 1) ? n * (n - 1) : 64'd1;
    q = ({16'b0, d} << (2 * FRAC)) / m;
    if (q[143:64] != 0) q = {80'b0, {64{1'b1}}};
    rt = root_floor(q[63:0]);
    return rt[31:0];
  endfunction

  function automatic logic [62:0] rand63();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[62:0];
  endfunction

  function automatic res_t make_result(logic k, int s, logic [1:0] vd, logic [39:0] lat,
                                       logic [31:0] mean, logic [31:0] sd);
    res_t r;
    r = '0;
    r.kind = k;
    r.stream = s[3:0];
    r.verdict = vd;
    r.total = c_tot[s];
    r.good = c_good[s];
    r.future = c_fut[s];
    r.expired = c_exp[s];
    r.lat = lat;
    r.mean = mean;
    r.sd = sd;
    return r;
  endfunction

  task automatic clear_window(int s);
    w_sum[s] = 0;
    w_sq[s] = '0;
    w_n[s] = '0;
    w_pk[s] = '0;
    w_lat[s] = '0;
  endtask

  // Advance the stream table by one accepted request and queue its results.
  task automatic predict_results(input req_t q);
    logic [63:0] now, win_us, lat, mean, sd;
    logic [31:0] wn;
    logic [1:0]  vd;
    longint      v;
    int          s, k;
    now = {1'b0, q.nw};
    win_us = ((m_win_s == 0) ? 64'd1 : {52'b0, m_win_s}) * 64'd1000000;
    if (q.cmd == CMD_SAMPLE) begin
      v = q.val;
      p_sum = clamp_s(p_sum + v, longint'(1) << 47);
      p_sq = add_sat(p_sq, v * v, '1);
      p_n = bump(p_n);
      if (!q.lst) return;
      s = q.strm;
      c_tot[s] = bump(c_tot[s]);
      if ({1'b0, q.en} > now + m_maxfut) begin
        vd = VERDICT_FUTURE;
        c_fut[s] = bump(c_fut[s]);
      end else if ({1'b0, q.st} + m_maxlat < now) begin
        vd = VERDICT_EXPIRED;
        c_exp[s] = bump(c_exp[s]);
      end else begin
        vd = VERDICT_GOOD;
        lat = (now > {1'b0, q.en}) ? now - {1'b0, q.en} : 64'd0;
        if (!w_act[s]) begin
          w_act[s] = 1'b1;
          w_start[s] = now;
          clear_window(s);
        end
        w_sum[s] = clamp_s(w_sum[s] + p_sum, longint'(1) << 55);
        w_sq[s] = add_sat(w_sq[s], p_sq, '1);
        wn = add_sat({32'b0, w_n[s]}, {32'b0, p_n}, {32'b0, MAX32});
        w_n[s] = wn;
        w_pk[s] = bump(w_pk[s]);
        w_lat[s] = add_sat(w_lat[s], lat, {8'b0, MAX56});
        c_good[s] = bump(c_good[s]);
      end
      p_sum = 0;
      p_sq = '0;
      p_n = '0;
      pending_results.push_back(make_result(KIND_VERDICT, s, vd, '0, '0, '0));
    end else begin
      k = 0;
      for (s = 0; s < NSTR; s++) begin
        if (!w_act[s] || now < w_start[s] + win_us) continue;
        lat = win_us;
        mean = '0;
        sd = '0;
        if (w_n[s] > 0) begin
          if (w_pk[s] > 0) begin
            lat = (w_lat[s] + w_pk[s] / 2) / w_pk[s];
            if (lat > MAX40) lat = MAX40;
          end
          mean = mean_fix(w_sum[s], w_n[s]);
          sd = std_fix(w_sum[s], w_sq[s], w_n[s]);
        end
        pending_results.push_back(make_result(KIND_STATS, s, VERDICT_GOOD, lat[39:0],
                                              mean[31:0], sd[31:0]));
        k++;
        w_start[s] = now;
        clear_window(s);
      end
      if (k > 0) pending_results[pending_results.size() - 1].last = 1'b1;
    end
  endtask

  // Request acceptance and result checking, both at the rising edge.
  always @(posedge clk) begin
    cyc++;
    in_fire = !rst && in_valid && in_ready;
    if (in_fire) begin
      predict_results(sample_feed[0]);
      void'(sample_feed.pop_front());
      n_acc++;
    end
    if (!rst && out_valid && out_ready) begin
      got = {kind, out_stream, verdict, total_count, good_count, future_count,
             expired_count, mean_latency_us, mean_value, std_value, last};
      n_res++;
      if (got.kind == KIND_STATS) n_windows++;
      if (pending_results.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("ERROR: unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          n_bad++;
          if (n_bad <= 10) begin
            $display("ERROR: result %0d mismatch", n_res);
            $display("  expected %p", want);
            $display("  actual   %p", got);
          end
        end
      end
    end
  end

  // Request driver; idles at random outside the quiet stretch.
  always @(negedge clk) begin
    if (in_valid && !in_fire) begin
      in_valid = 1'b1;
    end else if (!rst && sample_feed.size() > 0 &&
                 ((cyc > 3000 && cyc < 9000) || $urandom_range(0, 99) >= 14)) begin
      cmd = sample_feed[0].cmd;
      stream = sample_feed[0].strm;
      sample_value = sample_feed[0].val;
      last_sample = sample_feed[0].lst;
      start_us = sample_feed[0].st;
      end_us = sample_feed[0].en;
      now_us = sample_feed[0].nw;
      in_valid = 1'b1;
    end else begin
      in_valid = 1'b0;
    end
  end

  // Result receiver, with one long hold-off so the block backs up.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_ready = 1'b0;
    end else if (!hold_done && n_acc >= 120) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ready = 1'b0;
    end else begin
      out_ready = (cyc > 3000 && cyc < 9000) || $urandom_range(0, 99) >= 14;
    end
  end

  task automatic add_req(logic c, logic [3:0] s, logic signed [23:0] v, logic l,
                         logic [62:0] st, logic [62:0] en, logic [62:0] nw);
    req_t q;
    q.cmd = c;
    q.strm = s;
    q.val = v;
    q.lst = l;
    q.st = st;
    q.en = en;
    q.nw = nw;
    sample_feed.push_back(q);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [39:0] data);
    @(negedge clk);
    cfg_index = idx;
    cfg_data = data;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_WINDOW_SECONDS: m_win_s = data[11:0];
      REG_MAX_LATENCY:    m_maxlat = data;
      REG_MAX_FUTURE:     m_maxfut = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (sample_feed.size() != 0 || pending_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // Mostly well-formed packets on random streams, with ticks and stray samples.
  task automatic random_traffic(int count);
    logic [63:0]        win_us, nw;
    logic [62:0]        st, en;
    logic signed [23:0] val;
    logic [3:0]         s;
    int                 i, len, pick, lim, lat;
    win_us = ((m_win_s == 0) ? 64'd1 : {52'b0, m_win_s}) * 64'd1000000;
    lim = (m_maxlat < 3000) ? int'(m_maxlat) : 3000;
    i = 0;
    while (i < count) begin
      pick = $urandom_range(0, 99);
      nw = t_sim;
      if (pick < 8) begin
        add_req(CMD_TICK, 4'($urandom), 24'($urandom), 1'($urandom), rand63(), rand63(),
                nw[62:0]);
        i++;
      end else if (pick < 13) begin
        add_req(CMD_SAMPLE, 4'($urandom), 24'($urandom), 1'b0, rand63(), rand63(), rand63());
        i++;
      end else begin
        s = 4'($urandom);
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          lat = $urandom_range(0, lim);
          en = 63'(nw - 64'(lat));
          st = 63'(en - 63'($urandom_range(0, lim - lat)));
          if (m_maxfut > 0 && $urandom_range(0, 3) == 0)
            en = 63'(nw + 64'($urandom_range(0, (m_maxfut < 1000) ? int'(m_maxfut) : 1000)));
        end else if (pick < 85) begin
          en = 63'(nw + {24'b0, m_maxfut} + 64'd1 + 64'($urandom_range(0, 1000)));
          st = nw[62:0];
        end else begin
          en = nw[62:0];
          st = 63'(nw - {24'b0, m_maxlat} - 64'd1 - 64'($urandom_range(0, 1000)));
        end
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(0, 7) == 0) val = 24'($urandom);
          else val = 24'($urandom_range(0, 4000) - 2000);
          add_req(CMD_SAMPLE, s, val, j == len - 1, st, en, nw[62:0]);
        end
        i += len;
      end
      t_sim += 64'($urandom_range(0, int'(win_us / 6)));
    end
  endtask

  // Run limit.
  initial begin
    #200_000_000;
    $display("tb_windowed_stream_stats failed");
    $finish;
  end

  // Reset, directed requests, then random phases under several settings.
  initial begin
    m_win_s = 12'd60;
    m_maxlat = 40'd600000000;
    m_maxfut = '0;
    p_sum = 0;
    p_sq = '0;
    p_n = '0;
    for (int s = 0; s < NSTR; s++) begin
      clear_window(s);
      w_start[s] = '0;
      w_act[s] = 1'b0;
      c_tot[s] = '0;
      c_good[s] = '0;
      c_fut[s] = '0;
      c_exp[s] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Extreme samples, each verdict, the judging boundaries and the time extremes.
    add_req(CMD_SAMPLE, 4'd0, 24'sd8388607, 1'b0, '0, '0, '0);
    add_req(CMD_SAMPLE, 4'd0, -24'sd8388608, 1'b0, TMAX, TMAX, TMAX);
    add_req(CMD_SAMPLE, 4'd0, 24'sd100, 1'b1, T0 - 100, T0 - 5, T0);
    add_req(CMD_SAMPLE, 4'd15, -24'sd1, 1'b1, T0 - 10, T0 + 1, T0);
    add_req(CMD_SAMPLE, 4'd3, 24'sd5, 1'b1, T0 - 600000001, T0 - 600000001, T0);
    add_req(CMD_SAMPLE, 4'd5, 24'sd7, 1'b0, T0, T0, T0);
    add_req(CMD_SAMPLE, 4'd5, 24'sd9, 1'b1, T0 - 600000000, T0, T0);
    add_req(CMD_SAMPLE, 4'd7, 24'sd0, 1'b1, '0, '0, '0);
    add_req(CMD_SAMPLE, 4'd9, 24'sd1, 1'b1, '0, TMAX, TMAX);
    add_req(CMD_TICK, 4'd0, '0, 1'b0, '0, '0, T0);
    add_req(CMD_TICK, 4'd0, '0, 1'b0, '0, '0, T0 + 60000000 - 1);
    add_req(CMD_SAMPLE, 4'd0, 24'sd1000, 1'b0, T0, T0, T0 + 1000);
    add_req(CMD_SAMPLE, 4'd0, -24'sd3000, 1'b0, T0, T0, T0 + 1000);
    add_req(CMD_SAMPLE, 4'd0, 24'sd1, 1'b1, T0, T0 + 900, T0 + 1000);
    add_req(CMD_TICK, 4'd0, '0, 1'b0, '0, '0, T0 + 60000000);
    add_req(CMD_TICK, 4'd0, '0, 1'b0, '0, '0, T0 + 60000000);
    add_req(CMD_TICK, 4'd0, '0, 1'b0, '0, '0, T0 + 120000000);
    t_sim = {1'b0, T0} + 64'd120000000;
    wait_idle();

    write_reg(REG_WINDOW_SECONDS, 40'd1);
    write_reg(REG_MAX_LATENCY, MAX40);
    random_traffic(90);
    wait_idle();

    write_reg(REG_WINDOW_SECONDS, 40'd0);
    write_reg(REG_MAX_LATENCY, 40'd0);
    write_reg(REG_MAX_FUTURE, MAX40);
    write_reg(REG_SPARE, 40'd77);
    random_traffic(90);
    wait_idle();

    write_reg(REG_WINDOW_SECONDS, 40'd3600);
    write_reg(REG_MAX_LATENCY, 40'd5000);
    write_reg(REG_MAX_FUTURE, 40'd2000);
    random_traffic(90);
    wait_idle();

    write_reg(REG_WINDOW_SECONDS, 40'd2);
    write_reg(REG_MAX_LATENCY, 40'd600000000);
    write_reg(REG_MAX_FUTURE, 40'd100);
    random_traffic(90);
    // A tick at the latest time closes every active window.
    add_req(CMD_TICK, 4'd0, '0, 1'b0, '0, '0, TMAX);
    wait_idle();
    repeat (100) @(posedge clk);

    $display("Run covered %0d requests over five register settings.", n_acc);
    $display("%0d results checked, %0d of them window reports, %0d mismatches.",
             n_res, n_windows, n_bad);
    if (n_bad == 0) begin
      $display("tb_windowed_stream_stats passed");
    end else begin
      $display("tb_windowed_stream_stats failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/wss_pkg.sv
hdl/wss_ram.sv
hdl/wss_alu.sv
hdl/windowed_stream_stats.sv
dv/tb_windowed_stream_stats.sv
